// ----- hw/rtl/bcc_pkg.sv -----
package bcc_pkg;

   // Classifier states. Code 7 is never entered.
   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_DOWN    = 3'd1,
      ST_HOLD    = 3'd2,
      ST_UP      = 3'd3,
      ST_CONFIRM = 3'd4,
      ST_JUDGE   = 3'd5,
      ST_ACTION  = 3'd6
   } press_state_type;

   // Key event codes.
   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_SHORT  = 2'd1;
   localparam logic [1:0] EV_LONG   = 2'd2;
   localparam logic [1:0] EV_DOUBLE = 2'd3;

   // Register file layout.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PRESS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_WAIT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_EN    = 2'd3;

   localparam logic [15:0] LONG_PRESS_RESET   = 16'd300;
   localparam logic [15:0] MIN_PRESS_RESET    = 16'd20;
   localparam logic [15:0] RELEASE_WAIT_RESET = 16'd100;
   localparam logic        DOUBLE_EN_RESET    = 1'b1;

   typedef struct packed {
      logic [15:0] long_press_ms;
      logic [15:0] min_press_ms;
      logic [15:0] release_wait_ms;
      logic        double_click_enable;
   } cfg_type;

   typedef struct packed {
      press_state_type press_state;
      press_state_type previous_state;
      logic [31:0]     press_start_time;
      logic [31:0]     release_time;
      logic            second_press_flag;
      logic [1:0]      pending_code;
   } fsm_state_type;

endpackage

// ----- hw/rtl/bcc_req_if.sv -----
interface bcc_req_if;
   logic        valid;
   logic        ready;
   logic        pin_level;
   logic [31:0] now_ms;

   modport source (output valid, output pin_level, output now_ms, input ready);
   modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

// ----- hw/rtl/bcc_rsp_if.sv -----
interface bcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] key_event;
   logic       classifier_busy;

   modport source (output valid, output key_event, output classifier_busy, input ready);
   modport sink   (input valid, input key_event, input classifier_busy, output ready);
endinterface

// ----- hw/rtl/bcc_fsm.sv -----
// Next-state logic of the classifier for one poll.
module bcc_fsm (
   input  bcc_pkg::fsm_state_type cur,
   input  bcc_pkg::cfg_type       cfg,
   input  logic                   pin_level,
   input  logic [31:0]            now_ms,
   output bcc_pkg::fsm_state_type nxt,
   output logic [1:0]             key_event
);

   logic [31:0] held_ms;
   logic [31:0] wait_ms;

   assign held_ms = now_ms - cur.press_start_time;
   assign wait_ms = now_ms - cur.release_time;

   always_comb begin
      nxt       = cur;
      key_event = bcc_pkg::EV_NONE;

      // Level-driven transitions come first.
      if (!pin_level && (cur.press_state == bcc_pkg::ST_IDLE ||
                         cur.press_state == bcc_pkg::ST_CONFIRM)) begin
         nxt.previous_state = cur.press_state;
         nxt.press_state    = bcc_pkg::ST_DOWN;
      end else if (pin_level && cur.press_state == bcc_pkg::ST_HOLD) begin
         nxt.previous_state = cur.press_state;
         nxt.press_state    = bcc_pkg::ST_UP;
      end

      // Then the resulting state is handled once.
      case (nxt.press_state)
         bcc_pkg::ST_IDLE: begin
         end
         bcc_pkg::ST_DOWN: begin
            if (nxt.previous_state == bcc_pkg::ST_CONFIRM) begin
               nxt.second_press_flag = 1'b1;
            end
            nxt.press_start_time = now_ms;
            nxt.previous_state   = bcc_pkg::ST_DOWN;
            nxt.press_state      = bcc_pkg::ST_HOLD;
         end
         bcc_pkg::ST_HOLD: begin
            if (held_ms > {16'd0, cfg.long_press_ms}) begin
               nxt.pending_code   = bcc_pkg::EV_LONG;
               nxt.previous_state = bcc_pkg::ST_HOLD;
               nxt.press_state    = bcc_pkg::ST_JUDGE;
            end
         end
         bcc_pkg::ST_UP: begin
            if (nxt.previous_state == bcc_pkg::ST_IDLE) begin
               nxt.previous_state = bcc_pkg::ST_UP;
               nxt.press_state    = bcc_pkg::ST_IDLE;
            end else begin
               nxt.release_time   = now_ms;
               nxt.previous_state = bcc_pkg::ST_UP;
               if (held_ms > {16'd0, cfg.min_press_ms}) begin
                  nxt.press_state = bcc_pkg::ST_CONFIRM;
               end else begin
                  nxt.press_state = bcc_pkg::ST_IDLE;
               end
            end
         end
         bcc_pkg::ST_CONFIRM: begin
            if (wait_ms > {16'd0, cfg.release_wait_ms}) begin
               if (cur.second_press_flag && cfg.double_click_enable) begin
                  nxt.pending_code = bcc_pkg::EV_DOUBLE;
               end else begin
                  nxt.pending_code = bcc_pkg::EV_SHORT;
               end
               nxt.previous_state = bcc_pkg::ST_CONFIRM;
               nxt.press_state    = bcc_pkg::ST_JUDGE;
            end
         end
         bcc_pkg::ST_JUDGE: begin
            nxt.previous_state = bcc_pkg::ST_JUDGE;
            nxt.press_state    = bcc_pkg::ST_ACTION;
         end
         bcc_pkg::ST_ACTION: begin
            nxt.second_press_flag = 1'b0;
            if (!(cur.pending_code == bcc_pkg::EV_LONG && !pin_level)) begin
               nxt.previous_state = bcc_pkg::ST_ACTION;
               nxt.press_state    = bcc_pkg::ST_IDLE;
               key_event          = cur.pending_code;
            end
         end
         default: begin
            nxt.previous_state = nxt.press_state;
            nxt.press_state    = bcc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/button_click_classifier_core.sv -----
// Button click classifier core.
//
// The req_if channel carries one poll per transaction: the sampled button
// level (0 pressed, 1 released) and a free-running millisecond time stamp.
// For every accepted poll exactly one transaction leaves on rsp_if, carrying
// the key event (none, short, long or double press) and a busy flag that is
// set while the classifier is away from its idle state.
//
// A poll is first captured in an input register. The state update and the
// result are computed from that register by a single pass of compare and
// subtract logic and land in the result register, from which the response
// is offered on rsp_if. One poll can be accepted every cycle while the
// receiver does not stall; the state register loop closes within one pass
// of that logic.
//
// When the receiver stalls, the result register holds its transaction and
// the input register holds the next poll; req_if.ready drops once both are
// full. The csr port writes the four timing and mode registers; the user must
// use it only while no poll is in flight; the block does not enforce this.
// Reset (synchronous, active high) restores the register defaults, returns
// the classifier to idle and empties both pipeline registers.
module button_click_classifier_core (
   input  logic                                 clock,
   input  logic                                 reset,
   bcc_req_if.sink                              req_if,
   bcc_rsp_if.source                            rsp_if,
   input  logic                                 csr_we,
   input  logic [bcc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bcc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // Configuration registers.
   bcc_pkg::cfg_type cfg_ff;

   // Classifier state.
   bcc_pkg::fsm_state_type st_ff;
   bcc_pkg::fsm_state_type st_in;

   // Input register.
   logic        in_valid_ff;
   logic        in_level_ff;
   logic [31:0] in_now_ff;

   // Result register.
   logic        out_valid_ff;
   logic [1:0]  out_event_ff;
   logic        out_busy_ff;

   logic [1:0]  event_in;
   logic        advance;
   logic        fire;

   // The result register can take a new value when it is empty or drained.
   assign advance = !out_valid_ff || rsp_if.ready;
   assign fire    = in_valid_ff && advance;

   assign req_if.ready = !in_valid_ff || advance;

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.key_event       = out_event_ff;
   assign rsp_if.classifier_busy = out_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms       <= bcc_pkg::LONG_PRESS_RESET;
         cfg_ff.min_press_ms        <= bcc_pkg::MIN_PRESS_RESET;
         cfg_ff.release_wait_ms     <= bcc_pkg::RELEASE_WAIT_RESET;
         cfg_ff.double_click_enable <= bcc_pkg::DOUBLE_EN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bcc_pkg::CSR_LONG_PRESS:   cfg_ff.long_press_ms       <= csr_wdata;
            bcc_pkg::CSR_MIN_PRESS:    cfg_ff.min_press_ms        <= csr_wdata;
            bcc_pkg::CSR_RELEASE_WAIT: cfg_ff.release_wait_ms     <= csr_wdata;
            bcc_pkg::CSR_DOUBLE_EN:    cfg_ff.double_click_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Per-poll state update.
   bcc_fsm u_fsm (
      .cur       (st_ff),
      .cfg       (cfg_ff),
      .pin_level (in_level_ff),
      .now_ms    (in_now_ff),
      .nxt       (st_in),
      .key_event (event_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.press_state       <= bcc_pkg::ST_IDLE;
         st_ff.previous_state    <= bcc_pkg::ST_IDLE;
         st_ff.press_start_time  <= 32'd0;
         st_ff.release_time      <= 32'd0;
         st_ff.second_press_flag <= 1'b0;
         st_ff.pending_code      <= bcc_pkg::EV_NONE;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

   // Input register: loads whenever it is free or moving on.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_level_ff <= req_if.pin_level;
         in_now_ff   <= req_if.now_ms;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_event_ff <= event_in;
         out_busy_ff  <= (st_in.press_state != bcc_pkg::ST_IDLE);
      end
   end

   // A reported event always closes the classification, so busy is clear.
   a_event_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_event_ff != bcc_pkg::EV_NONE) |-> !out_busy_ff)
      else $error("event reported while classifier still busy");

   // Down and up are handled within the poll that enters them.
   a_no_transient: assert property (@(posedge clock) disable iff (reset)
      st_ff.press_state != bcc_pkg::ST_DOWN && st_ff.press_state != bcc_pkg::ST_UP)
      else $error("transient state left in state register");

   // Judge and action always carry a classification.
   a_pending_set: assert property (@(posedge clock) disable iff (reset)
      (st_ff.press_state == bcc_pkg::ST_JUDGE || st_ff.press_state == bcc_pkg::ST_ACTION)
      |-> st_ff.pending_code != bcc_pkg::EV_NONE)
      else $error("judge or action without pending code");

   // Every processed poll yields a response on the next cycle.
   a_fire_out: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed poll produced no response");

   // Backpressure on the input comes only from a stalled response.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (in_valid_ff && out_valid_ff && !rsp_if.ready))
      else $error("input stalled without a stalled response");

endmodule
